[rtl/i2cm_pkg.sv]
// Shared types and constants for the I2C master bit engine.
// Depends on nothing; imported by i2cm_step and i2c_master_bit_engine_core.

package i2cm_pkg;

    // Bits in one bus byte, and the same figure at bit-counter width.
    localparam int         BITS_PER_BYTE = 8;
    localparam logic [3:0] BYTE_BITS     = 4'(BITS_PER_BYTE);

    // Reset value of the delay-unit length register.
    localparam logic [7:0] TPD_RESET = 8'd10;

    // Command codes, as carried on the request type field.
    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_ACK   = 3'd5
    } t_cmd;

    // Full sequencer state carried from one tick to the next.
    typedef struct packed {
        t_cmd       cmd;
        logic [3:0] phase;
        logic [3:0] bit_cnt;
        logic [7:0] delay;
        logic [7:0] shift;
        logic       scl;
        logic       sda;
        logic       sda_oe;
        logic       nack;
        logic [7:0] rx_hold;
    } t_state;

    // One result, as presented on the output channel.
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       nack;
    } t_result;

    localparam t_state STATE_RESET = '{
        cmd:     CMD_IDLE,
        phase:   4'd0,
        bit_cnt: 4'd0,
        delay:   8'd0,
        shift:   8'd0,
        scl:     1'b1,
        sda:     1'b1,
        sda_oe:  1'b1,
        nack:    1'b0,
        rx_hold: 8'd0
    };

endpackage

[rtl/i2cm_step.sv]
// Next-state and result logic for one tick of the I2C master bit engine.
// Depends on i2cm_pkg for the state, result and command types.

module i2cm_step import i2cm_pkg::*; (
    input  t_state     i_state,
    input  logic [7:0] i_tpd,
    input  logic [2:0] i_req_type,
    input  logic [7:0] i_tx_byte,
    input  logic       i_sda_in,
    output t_state     o_state,
    output t_result    o_result
);

    t_state     n_st;
    logic       done;
    logic [7:0] tpd_eff;
    logic [8:0] delay_inc;
    logic [3:0] p;

    // A zero unit length behaves as one tick per unit.
    assign tpd_eff   = (i_tpd == 8'd0) ? 8'd1 : i_tpd;
    assign delay_inc = {1'b0, i_state.delay} + 9'd1;
    assign p         = i_state.phase;

    always_comb begin
        n_st = i_state;
        done = 1'b0;

        if (i_state.cmd == CMD_IDLE) begin
            // Idle: take a new command and apply its opening pin actions.
            if (i_req_type inside {[CMD_START:CMD_ACK]}) begin
                n_st.phase   = 4'd0;
                n_st.bit_cnt = 4'd0;
                n_st.delay   = 8'd0;
                n_st.cmd     = t_cmd'(i_req_type);
                case (t_cmd'(i_req_type))
                    CMD_START: begin
                        n_st.sda_oe = 1'b1;
                        n_st.sda    = 1'b1;
                        n_st.scl    = 1'b1;
                    end
                    CMD_STOP: begin
                        n_st.sda_oe = 1'b1;
                        n_st.scl    = 1'b0;
                        n_st.sda    = 1'b0;
                    end
                    CMD_WRITE: begin
                        n_st.sda_oe = 1'b1;
                        n_st.scl    = 1'b0;
                        n_st.shift  = i_tx_byte;
                        n_st.sda    = i_tx_byte[7];
                    end
                    CMD_READ: begin
                        n_st.sda_oe = 1'b0;
                        n_st.scl    = 1'b0;
                        n_st.shift  = 8'd0;
                    end
                    default: begin
                        n_st.sda_oe = 1'b0;
                        n_st.sda    = 1'b1;
                    end
                endcase
            end
        end else if (delay_inc >= {1'b0, tpd_eff}) begin
            // End of a delay unit: advance the command's phase.
            n_st.delay = 8'd0;
            case (i_state.cmd)
                CMD_START: begin
                    if (p == 4'd4) begin
                        n_st.sda = 1'b0;
                    end
                    if (p >= 4'd7) begin
                        n_st.scl     = 1'b0;
                        n_st.cmd     = CMD_IDLE;
                        n_st.phase   = 4'd0;
                        n_st.bit_cnt = 4'd0;
                        done         = 1'b1;
                    end else begin
                        n_st.phase = p + 4'd1;
                    end
                end
                CMD_STOP: begin
                    if (p == 4'd2) begin
                        n_st.scl = 1'b1;
                    end
                    if (p == 4'd5) begin
                        n_st.sda = 1'b1;
                    end
                    if (p >= 4'd6) begin
                        n_st.cmd     = CMD_IDLE;
                        n_st.phase   = 4'd0;
                        n_st.bit_cnt = 4'd0;
                        done         = 1'b1;
                    end else begin
                        n_st.phase = p + 4'd1;
                    end
                end
                CMD_ACK: begin
                    if (p == 4'd0) begin
                        n_st.scl   = 1'b1;
                        n_st.phase = 4'd1;
                    end else if (i_sda_in) begin
                        // No acknowledge: flag it and run a stop at once.
                        n_st.nack   = 1'b1;
                        n_st.cmd    = CMD_STOP;
                        n_st.phase  = 4'd0;
                        n_st.sda_oe = 1'b1;
                        n_st.scl    = 1'b0;
                        n_st.sda    = 1'b0;
                    end else begin
                        n_st.nack    = 1'b0;
                        n_st.scl     = 1'b0;
                        n_st.cmd     = CMD_IDLE;
                        n_st.phase   = 4'd0;
                        n_st.bit_cnt = 4'd0;
                        done         = 1'b1;
                    end
                end
                CMD_WRITE: begin
                    if (i_state.bit_cnt >= BYTE_BITS) begin
                        // Trailing unit after the last bit.
                        n_st.cmd     = CMD_IDLE;
                        n_st.phase   = 4'd0;
                        n_st.bit_cnt = 4'd0;
                        done         = 1'b1;
                    end else begin
                        if (p == 4'd0) begin
                            n_st.scl = 1'b1;
                        end
                        if (p == 4'd1) begin
                            n_st.shift = {i_state.shift[6:0], 1'b0};
                        end
                        if (p == 4'd3) begin
                            n_st.scl = 1'b0;
                        end
                        if (p >= 4'd4) begin
                            n_st.phase   = 4'd0;
                            n_st.bit_cnt = i_state.bit_cnt + 4'd1;
                            if (n_st.bit_cnt < BYTE_BITS) begin
                                n_st.sda = i_state.shift[7];
                            end
                        end else begin
                            n_st.phase = p + 4'd1;
                        end
                    end
                end
                CMD_READ: begin
                    // SDA is sampled as SCL rises.
                    if (p == 4'd2) begin
                        n_st.scl   = 1'b1;
                        n_st.shift = {i_state.shift[6:0], i_sda_in};
                    end
                    if (p >= 4'd3) begin
                        n_st.phase   = 4'd0;
                        n_st.bit_cnt = i_state.bit_cnt + 4'd1;
                        if (n_st.bit_cnt >= BYTE_BITS) begin
                            n_st.rx_hold = n_st.shift;
                            n_st.cmd     = CMD_IDLE;
                            n_st.phase   = 4'd0;
                            n_st.bit_cnt = 4'd0;
                            done         = 1'b1;
                        end else begin
                            n_st.scl = 1'b0;
                        end
                    end else begin
                        n_st.phase = p + 4'd1;
                    end
                end
                default: begin
                    n_st.cmd     = CMD_IDLE;
                    n_st.phase   = 4'd0;
                    n_st.bit_cnt = 4'd0;
                    done         = 1'b1;
                end
            endcase
        end else begin
            n_st.delay = delay_inc[7:0];
        end
    end

    // The result shows the state after this tick.
    assign o_state             = n_st;
    assign o_result.scl_level  = n_st.scl;
    assign o_result.sda_level  = n_st.sda;
    assign o_result.sda_drive  = n_st.sda_oe;
    assign o_result.busy_res   = (n_st.cmd != CMD_IDLE);
    assign o_result.done_res   = done;
    assign o_result.rx_byte    = n_st.rx_hold;
    assign o_result.nack       = n_st.nack;

endmodule

[rtl/i2c_master_bit_engine_core.sv]
// Top level of the I2C master bit engine: state registers, result queue, config.
// Depends on i2cm_pkg and i2cm_step.
//
//   Channel   Direction  Handshake                  Payload
//   in        sink       i_in_valid / o_in_stall    i_req_type, i_tx_byte, i_sda_in
//   out       source     o_out_valid / i_out_stall  o_scl_level .. o_nack
//   cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_data (ticks_per_delay)
//
// Each request is one bus tick; the step logic is combinational, and the result is
// registered into the output register, or into the skid entry behind a waiting result.
// A two-entry result queue (output register plus skid entry) lets a request be
// taken while a result waits; o_in_stall rises only when both entries are full.
// Reset is synchronous and active low; it clears the sequencer state and the queue.

module i2c_master_bit_engine_core import i2cm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_req_type,
    input  logic [7:0] i_tx_byte,
    input  logic       i_sda_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_scl_level,
    output logic       o_sda_level,
    output logic       o_sda_drive,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_rx_byte,
    output logic       o_nack,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    t_state     r_st;
    t_state     n_st;
    t_result    n_res;
    t_result    r_head;
    t_result    r_skid;
    logic       r_head_vld;
    logic       r_skid_vld;
    logic [7:0] r_tpd;
    logic       push;
    logic       pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_vld;
    assign push        = i_in_valid && !r_skid_vld;
    assign pop         = r_head_vld && !i_out_stall;

    // Delay-unit length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpd <= TPD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tpd <= i_cfg_data;
        end
    end

    // One tick of the bus sequencer.
    i2cm_step u_step (
        .i_state    (r_st),
        .i_tpd      (r_tpd),
        .i_req_type (i_req_type),
        .i_tx_byte  (i_tx_byte),
        .i_sda_in   (i_sda_in),
        .o_state    (n_st),
        .o_result   (n_res)
    );

    // Sequencer state advances once per accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= STATE_RESET;
        end else if (push) begin
            r_st <= n_st;
        end
    end

    // Result queue: output register with a skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (pop && r_skid_vld) begin
            r_head     <= r_skid;
            r_skid_vld <= 1'b0;
        end else if (pop || !r_head_vld) begin
            r_head_vld <= push;
            if (push) begin
                r_head <= n_res;
            end
        end else if (push) begin
            r_skid     <= n_res;
            r_skid_vld <= 1'b1;
        end
    end

    assign o_out_valid = r_head_vld;
    assign o_scl_level = r_head.scl_level;
    assign o_sda_level = r_head.sda_level;
    assign o_sda_drive = r_head.sda_drive;
    assign o_busy_res  = r_head.busy_res;
    assign o_done_res  = r_head.done_res;
    assign o_rx_byte   = r_head.rx_byte;
    assign o_nack      = r_head.nack;

    // A finished command never reports itself as still busy.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head_vld && r_head.done_res |-> !r_head.busy_res)
        else $error("done result reported while busy");

    // The skid entry is only ever filled behind a full output register.
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_head_vld)
        else $error("skid entry holds a result with the output register empty");

    // An idle sequencer has its phase and bit counters cleared.
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.cmd == CMD_IDLE |-> r_st.phase == 4'd0 && r_st.bit_cnt == 4'd0)
        else $error("idle with phase or bit count left over");

    // The bit counter never runs past one byte.
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.bit_cnt <= BYTE_BITS)
        else $error("bit counter beyond one byte");

endmodule

[test/tb.sv]
// Self-checking testbench for i2c_master_bit_engine_core, one request per bus tick.
// Predicts every pin result from its own model of the sequencer; needs i2cm_pkg and
// the RTL of the block, nothing else.

module tb;
    import i2cm_pkg::*;

    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_TICKS = 400;
    localparam int CYCLE_LIMIT  = 500000;

    // Sequencer state as the testbench models it, plus the done flag of the last tick.
    typedef struct packed {
        t_cmd       cmd;
        logic [3:0] phase;
        logic [3:0] bit_cnt;
        logic [7:0] delay;
        logic [7:0] shift;
        logic [7:0] rx;
        logic       scl;
        logic       sda;
        logic       sda_oe;
        logic       nack;
        logic       done;
    } t_sequencer;

    // Pins and status expected from one tick.
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       drive;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       nack;
    } t_pins;

    // One bus tick as offered on the request channel.
    typedef struct packed {
        logic [2:0] req;
        logic [7:0] tx;
        logic       sda;
    } t_tick;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [2:0] i_req_type  = CMD_IDLE;
    logic [7:0] i_tx_byte   = 8'd0;
    logic       i_sda_in    = 1'b0;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [7:0] i_cfg_data  = 8'd0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_scl_level;
    logic       o_sda_level;
    logic       o_sda_drive;
    logic       o_busy_res;
    logic       o_done_res;
    logic [7:0] o_rx_byte;
    logic       o_nack;
    logic       o_cfg_ready;

    i2c_master_bit_engine_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_tx_byte   (i_tx_byte),
        .i_sda_in    (i_sda_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_scl_level (o_scl_level),
        .o_sda_level (o_sda_level),
        .o_sda_drive (o_sda_drive),
        .o_busy_res  (o_busy_res),
        .o_done_res  (o_done_res),
        .o_rx_byte   (o_rx_byte),
        .o_nack      (o_nack),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    t_sequencer engine_now;
    t_sequencer engine_plan;
    logic [7:0] unit_ticks = TPD_RESET;
    t_tick      tick_q[$];
    t_pins      expected_pins[$];
    bit         in_taken     = 1'b0;
    bit         jitter       = 1'b0;
    bit         want_hold    = 1'b0;
    int         send_gap     = 0;
    int         stall_left   = 0;
    int         hold_left    = 0;
    int         ticks_queued = 0;
    int         results_seen = 0;
    int         errors       = 0;
    int         cycles       = 0;
    int         reg_writes   = 0;
    int         nack_stops   = 0;
    int         stall_cycles = 0;
    int         cmds_issued[8];

    // Advances the sequencer by one tick, as the block does for one accepted request.
    function automatic t_sequencer bus_tick(input t_sequencer s, input logic [2:0] req,
                                            input logic [7:0] tx, input logic sda_in);
        t_sequencer n;
        logic [7:0] tpd;
        logic [3:0] p;
        logic       end_cmd;
        logic       go_stop;
        n       = s;
        n.done  = 1'b0;
        end_cmd = 1'b0;
        go_stop = 1'b0;
        tpd     = (unit_ticks == 8'd0) ? 8'd1 : unit_ticks;
        p       = s.phase;
        if (s.cmd == CMD_IDLE) begin
            // A command is taken only when idle; its opening pin actions apply at once.
            if (req >= CMD_START && req <= CMD_ACK) begin
                n.phase   = 4'd0;
                n.bit_cnt = 4'd0;
                n.delay   = 8'd0;
                n.cmd     = t_cmd'(req);
                case (n.cmd)
                    CMD_START: begin
                        n.sda_oe = 1'b1;
                        n.sda    = 1'b1;
                        n.scl    = 1'b1;
                    end
                    CMD_STOP: go_stop = 1'b1;
                    CMD_WRITE: begin
                        n.sda_oe = 1'b1;
                        n.scl    = 1'b0;
                        n.shift  = tx;
                        n.sda    = tx[7];
                    end
                    CMD_READ: begin
                        n.sda_oe = 1'b0;
                        n.scl    = 1'b0;
                        n.shift  = 8'd0;
                    end
                    default: begin
                        n.sda_oe = 1'b0;
                        n.sda    = 1'b1;
                    end
                endcase
            end
        end else if ({1'b0, s.delay} + 9'd1 < {1'b0, tpd}) begin
            n.delay = s.delay + 8'd1;
        end else begin
            // End of a delay unit: the pin actions of the current step.
            n.delay = 8'd0;
            case (s.cmd)
                CMD_START: begin
                    if (p == 4'd4) n.sda = 1'b0;
                    if (p >= 4'd7) begin
                        n.scl   = 1'b0;
                        end_cmd = 1'b1;
                    end else begin
                        n.phase = p + 4'd1;
                    end
                end
                CMD_STOP: begin
                    if (p == 4'd2) n.scl = 1'b1;
                    if (p == 4'd5) n.sda = 1'b1;
                    if (p >= 4'd6) end_cmd = 1'b1;
                    else n.phase = p + 4'd1;
                end
                CMD_ACK: begin
                    if (p == 4'd0) begin
                        n.scl   = 1'b1;
                        n.phase = 4'd1;
                    end else if (sda_in) begin
                        n.nack  = 1'b1;
                        go_stop = 1'b1;
                    end else begin
                        n.nack  = 1'b0;
                        n.scl   = 1'b0;
                        end_cmd = 1'b1;
                    end
                end
                CMD_WRITE: begin
                    if (s.bit_cnt >= BYTE_BITS) begin
                        end_cmd = 1'b1;
                    end else begin
                        if (p == 4'd0) n.scl = 1'b1;
                        if (p == 4'd1) n.shift = {s.shift[6:0], 1'b0};
                        if (p == 4'd3) n.scl = 1'b0;
                        if (p >= 4'd4) begin
                            n.phase   = 4'd0;
                            n.bit_cnt = s.bit_cnt + 4'd1;
                            if (n.bit_cnt < BYTE_BITS) n.sda = n.shift[7];
                        end else begin
                            n.phase = p + 4'd1;
                        end
                    end
                end
                CMD_READ: begin
                    // The bit is taken as SCL rises; SCL stays high after the last one.
                    if (p == 4'd2) begin
                        n.scl   = 1'b1;
                        n.shift = {s.shift[6:0], sda_in};
                    end
                    if (p >= 4'd3) begin
                        n.phase   = 4'd0;
                        n.bit_cnt = s.bit_cnt + 4'd1;
                        if (n.bit_cnt >= BYTE_BITS) begin
                            n.rx    = n.shift;
                            end_cmd = 1'b1;
                        end else begin
                            n.scl = 1'b0;
                        end
                    end else begin
                        n.phase = p + 4'd1;
                    end
                end
                default: end_cmd = 1'b1;
            endcase
        end
        if (go_stop) begin
            n.cmd    = CMD_STOP;
            n.phase  = 4'd0;
            n.sda_oe = 1'b1;
            n.scl    = 1'b0;
            n.sda    = 1'b0;
        end
        if (end_cmd) begin
            n.cmd     = CMD_IDLE;
            n.phase   = 4'd0;
            n.bit_cnt = 4'd0;
            n.done    = 1'b1;
        end
        return n;
    endfunction

    task automatic check_pin(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Queues one tick and advances the planning copy of the sequencer with it.
    task automatic push_tick(input logic [2:0] req, input logic [7:0] tx, input logic sda);
        t_tick      t;
        t_sequencer prior;
        t.req = req;
        t.tx  = tx;
        t.sda = sda;
        tick_q.push_back(t);
        ticks_queued++;
        prior       = engine_plan;
        engine_plan = bus_tick(engine_plan, req, tx, sda);
        if (prior.cmd == CMD_IDLE && engine_plan.cmd != CMD_IDLE) cmds_issued[req]++;
        if (prior.cmd == CMD_ACK && engine_plan.cmd == CMD_STOP) nack_stops++;
    endtask

    // Feeds busy ticks until the planned sequencer is idle again. Requests offered
    // meanwhile must be ignored; sda_pin below zero means a random SDA level.
    task automatic run_out(input int sda_pin, input int noise_pct);
        logic [2:0] req;
        while (engine_plan.cmd != CMD_IDLE) begin
            req = CMD_IDLE;
            if ($urandom_range(0, 99) < noise_pct) req = 3'($urandom_range(1, 7));
            push_tick(req, 8'($urandom), (sda_pin < 0) ? 1'($urandom) : 1'(sda_pin));
        end
    endtask

    // One command from idle, with up to two idle ticks in front and run to completion.
    task automatic issue(input logic [2:0] code, input logic [7:0] tx_val,
                         input int sda_pin, input int noise_pct);
        logic [2:0] idle_req;
        run_out(-1, noise_pct);
        repeat ($urandom_range(0, 2)) begin
            idle_req = ($urandom_range(0, 2) == 0) ? 3'd0 : 3'($urandom_range(6, 7));
            push_tick(idle_req, 8'($urandom), 1'($urandom));
        end
        push_tick(code, tx_val, (sda_pin < 0) ? 1'($urandom) : 1'(sda_pin));
        run_out(sda_pin, noise_pct);
    endtask

    // Mostly a well-formed bus transfer with random content; now and then a broken one.
    task automatic transaction();
        logic [2:0] code;
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                code = 3'($urandom_range(1, 7));
                issue(code, 8'($urandom), -1, 25);
            end
        end else begin
            issue(CMD_START, 8'($urandom), -1, 25);
            issue(CMD_WRITE, 8'($urandom), -1, 25);
            issue(CMD_ACK, 8'($urandom), int'($urandom_range(0, 7) == 0), 25);
            if (!engine_plan.nack) begin
                repeat ($urandom_range(1, 2)) begin
                    if ($urandom_range(0, 1)) begin
                        issue(CMD_WRITE, 8'($urandom), -1, 25);
                        issue(CMD_ACK, 8'($urandom), int'($urandom_range(0, 7) == 0), 25);
                    end else begin
                        issue(CMD_READ, 8'($urandom), -1, 25);
                    end
                end
                issue(CMD_STOP, 8'($urandom), -1, 25);
            end
        end
    endtask

    // Waits until every queued request has produced its checked result.
    task automatic drain();
        while (results_seen != ticks_queued) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [7:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        unit_ticks = value;
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Request driver: offers queued ticks, holding each until it is taken.
    always @(negedge i_clk) begin : request_driver
        t_tick next_tick;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // Held until accepted; the payload stays as it is.
        end else if (send_gap > 0) begin
            send_gap--;
            i_in_valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
            if (jitter && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(0, 16);
                i_in_valid <= 1'b0;
            end else begin
                next_tick = tick_q.pop_front();
                i_in_valid <= 1'b1;
                i_req_type <= next_tick.req;
                i_tx_byte  <= next_tick.tx;
                i_sda_in   <= next_tick.sda;
            end
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Result receiver: random stall bursts, and one long hold-off when asked for.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (want_hold) begin
            want_hold = 1'b0;
            hold_left = LONG_HOLD - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (jitter && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 16);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Monitor: checks each delivered result, then predicts for each accepted request.
    always @(posedge i_clk) begin : result_monitor
        t_pins want;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && o_in_stall) stall_cycles++;
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_pins.size() == 0) begin
                    errors++;
                    $display("%0t: result arrived with nothing expected", $time);
                end else begin
                    want = expected_pins.pop_front();
                    check_pin("scl_level", 8'(want.scl), 8'(o_scl_level));
                    check_pin("sda_level", 8'(want.sda), 8'(o_sda_level));
                    check_pin("sda_drive", 8'(want.drive), 8'(o_sda_drive));
                    check_pin("busy_res", 8'(want.busy), 8'(o_busy_res));
                    check_pin("done_res", 8'(want.done), 8'(o_done_res));
                    check_pin("rx_byte", want.rx, o_rx_byte);
                    check_pin("nack", 8'(want.nack), 8'(o_nack));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                in_taken   = 1'b1;
                engine_now = bus_tick(engine_now, i_req_type, i_tx_byte, i_sda_in);
                want.scl   = engine_now.scl;
                want.sda   = engine_now.sda;
                want.drive = engine_now.sda_oe;
                want.busy  = (engine_now.cmd != CMD_IDLE);
                want.done  = engine_now.done;
                want.rx    = engine_now.rx;
                want.nack  = engine_now.nack;
                expected_pins.push_back(want);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        int         base;
        int         r;
        logic [7:0] tpd_pick;
        engine_now.cmd     = CMD_IDLE;
        engine_now.phase   = 4'd0;
        engine_now.bit_cnt = 4'd0;
        engine_now.delay   = 8'd0;
        engine_now.shift   = 8'd0;
        engine_now.rx      = 8'd0;
        engine_now.scl     = 1'b1;
        engine_now.sda     = 1'b1;
        engine_now.sda_oe  = 1'b1;
        engine_now.nack    = 1'b0;
        engine_now.done    = 1'b0;
        engine_plan        = engine_now;
        for (int k = 0; k < 8; k++) cmds_issued[k] = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        jitter = 1'b1;

        // Directed: unknown codes and a stop from idle at the reset delay length.
        issue(3'd6, 8'h00, -1, 0);
        issue(3'd7, 8'hFF, -1, 0);
        issue(CMD_STOP, 8'h00, -1, 0);

        // A zero register acts as one tick per unit; byte and acknowledge extremes.
        cfg_write(8'd0);
        issue(CMD_START, 8'h00, -1, 0);
        issue(CMD_WRITE, 8'hFF, -1, 0);
        issue(CMD_ACK, 8'h00, 0, 0);
        issue(CMD_WRITE, 8'h00, -1, 0);
        issue(CMD_ACK, 8'h00, 1, 0);
        issue(CMD_START, 8'h00, -1, 100);
        issue(CMD_WRITE, 8'hA5, -1, 100);
        issue(CMD_ACK, 8'h00, 0, 100);
        issue(CMD_READ, 8'h00, 1, 0);
        issue(CMD_READ, 8'h00, 0, 0);
        issue(CMD_STOP, 8'h00, -1, 0);
        issue(CMD_ACK, 8'h00, 0, 0);
        issue(CMD_READ, 8'h00, -1, 0);

        // Longest unit, left part-way through, then shortened while the unit runs.
        cfg_write(8'd255);
        push_tick(CMD_START, 8'h00, 1'b0);
        repeat (300) push_tick(CMD_IDLE, 8'($urandom), 1'($urandom));
        cfg_write(8'd3);
        run_out(-1, 25);

        // The receiver holds off long enough for the block to stall its requests.
        cfg_write(8'd1);
        want_hold = 1'b1;
        issue(CMD_START, 8'h00, -1, 25);
        issue(CMD_WRITE, 8'($urandom), -1, 25);
        issue(CMD_READ, 8'h00, -1, 25);
        issue(CMD_STOP, 8'h00, -1, 25);

        // Random phases, mostly short delay units.
        base = ticks_queued;
        while (ticks_queued - base < RANDOM_TICKS) begin
            r = $urandom_range(0, 9);
            if (r == 0) tpd_pick = 8'd0;
            else if (r <= 5) tpd_pick = 8'd1;
            else if (r <= 7) tpd_pick = 8'd2;
            else if (r == 8) tpd_pick = 8'd3;
            else tpd_pick = 8'($urandom_range(4, 8));
            cfg_write(tpd_pick);
            jitter = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 2)) transaction();
            if ($urandom_range(0, 5) == 0) begin
                push_tick(3'($urandom_range(1, 5)), 8'($urandom), 1'($urandom));
                repeat ($urandom_range(1, 40)) push_tick(CMD_IDLE, 8'($urandom), 1'($urandom));
            end
        end

        // Closing stretch with no idling on either side.
        cfg_write(8'd1);
        jitter = 1'b0;
        transaction();
        drain();
        repeat (8) @(posedge i_clk);

        $display("Ran %0d bus ticks over %0d register writes: %0d start, %0d stop, %0d write,",
                 ticks_queued, reg_writes, cmds_issued[CMD_START], cmds_issued[CMD_STOP],
                 cmds_issued[CMD_WRITE]);
        $display("%0d read and %0d ack commands, %0d nack stops, %0d cycles of request stall.",
                 cmds_issued[CMD_READ], cmds_issued[CMD_ACK], nack_stops, stall_cycles);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
